### rtl/core/ctt_pkg.sv
package ctt_pkg;

    // table size and key layout
    localparam int CttCapacity = 64;
    localparam int PortShift   = 16;

    localparam int AddrW    = 32;
    localparam int PortW    = 16;
    localparam int FieldW   = 16;
    localparam int StampW   = 32;
    localparam int PayloadW = 3 * FieldW;

    // operation kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // operation word walking down the cell chain
    typedef struct packed {
        logic [1:0]            kind;
        logic [2*AddrW-1:0]    addrs;
        logic [2*PortW-1:0]    ports;
        logic [PayloadW-1:0]   payload;
        logic [StampW-1:0]     stamp;
        logic                  hit;
        logic                  done;
        logic [StampW-1:0]     best_age;
        logic [PayloadW-1:0]   best_payload;
    } t_tok;

endpackage

### rtl/core/ctt_cell.sv
module ctt_cell
    import ctt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_stall,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_tok_valid,
    output t_tok o_tok
);

    logic                  r_valid;
    logic [2*AddrW-1:0]    r_addrs;
    logic [2*PortW-1:0]    r_ports;
    logic [PayloadW-1:0]   r_payload;
    logic [StampW-1:0]     r_stamp;
    logic                  r_tok_v;
    t_tok                  r_tok;

    logic                  match;
    logic [StampW-1:0]     age;
    logic                  claim;
    logic                  drop;
    t_tok                  n_tok;

    // key compare and age against the counter taken at entry
    assign match = r_valid && (r_addrs == i_tok.addrs) && (r_ports == i_tok.ports);
    assign age   = i_tok.stamp - r_stamp;

    always_comb begin
        n_tok = i_tok;
        claim = 1'b0;
        drop  = 1'b0;
        case (i_tok.kind)
            KIND_INSERT: begin
                // first free cell along the chain takes the entry
                if (!r_valid && !i_tok.done) begin
                    claim      = 1'b1;
                    n_tok.done = 1'b1;
                end
            end
            KIND_LOOKUP: begin
                if (match && (!i_tok.hit || age < i_tok.best_age)) begin
                    n_tok.hit          = 1'b1;
                    n_tok.best_age     = age;
                    n_tok.best_payload = r_payload;
                end
            end
            KIND_REMOVE: begin
                if (match) begin
                    drop = 1'b1;
                    if (!i_tok.hit || age > i_tok.best_age) begin
                        n_tok.hit          = 1'b1;
                        n_tok.best_age     = age;
                        n_tok.best_payload = r_payload;
                    end
                end
            end
            default: ;
        endcase
    end

    // control: entry valid and word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok_v <= 1'b0;
        end else if (!i_stall) begin
            r_tok_v <= i_tok_valid;
            if (i_tok_valid && claim) begin
                r_valid <= 1'b1;
            end else if (i_tok_valid && drop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // entry contents and forwarded word
    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_tok <= n_tok;
            if (i_tok_valid && claim) begin
                r_addrs   <= i_tok.addrs;
                r_ports   <= i_tok.ports;
                r_payload <= i_tok.payload;
                r_stamp   <= i_tok.stamp + 1'b1;
            end
        end
    end

    assign o_tok_valid = r_tok_v;
    assign o_tok       = r_tok;

endmodule

### rtl/core/connection_tuple_table_core.sv
// Flow table keyed by local/foreign address and port.
// Slave channel s_axis: one word per operation; tuser holds the kind
// (insert, lookup, remove all matches), tdata the key and insert payload.
// Master channel m_axis: one result word per operation; tuser holds the
// status (done/found, no match, pool full), tdata the reported payload.
// Each entry lives in one cell of a chain of CAPACITY cells. An accepted
// operation walks the chain one cell per clock while the chain is not
// stalled, and its result is then registered. One operation is in the
// chain at a time: the next word is taken the cycle after the result
// reaches the output register, so no word is taken while one is in the chain.
// The output register lets a new word enter while a result still waits.
// If the receiver stalls with a result held and another reaches the end of
// the chain, the whole chain freezes until the output register frees up.
// Synchronous reset empties every entry and clears the insert counter; the
// block accepts words in the first cycle after reset.
module connection_tuple_table_core
    import ctt_pkg::*;
#(
    parameter int CAPACITY = CttCapacity
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] local_addr, [63:32] foreign_addr, [79:64] local_port,
    // [95:80] foreign_port, [111:96] record_version,
    // [127:112] greeting_version, [143:128] suite_list_length
    input  logic [143:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] out_record_version, [31:16] out_greeting_version,
    // [47:32] out_suite_list_length
    output logic [47:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);

    logic                r_busy;
    logic [StampW-1:0]   r_stamp;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [PayloadW-1:0] r_out_payload;

    logic                accept;
    logic                stall;
    logic                load;
    logic [1:0]          n_status;
    logic [PayloadW-1:0] n_payload;
    t_tok                entry;
    t_tok                last;
    logic [CAPACITY:0]   tok_v;
    t_tok                tok [CAPACITY+1];

    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // build the operation word from the slave channel
    always_comb begin
        entry              = '0;
        entry.kind         = s_axis_tuser;
        entry.addrs        = {s_axis_tdata[31:0], s_axis_tdata[63:32]};
        entry.ports        = ({16'd0, s_axis_tdata[79:64]} << PortShift)
                           | {16'd0, s_axis_tdata[95:80]};
        entry.payload      = {s_axis_tdata[111:96], s_axis_tdata[127:112],
                              s_axis_tdata[143:128]};
        entry.stamp        = r_stamp;
    end

    assign tok_v[0] = accept;
    assign tok[0]   = entry;

    // chain of table cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ctt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_stall     (stall),
            .i_tok_valid (tok_v[g]),
            .i_tok       (tok[g]),
            .o_tok_valid (tok_v[g+1]),
            .o_tok       (tok[g+1])
        );
    end

    assign last  = tok[CAPACITY];
    assign stall = tok_v[CAPACITY] && r_out_valid && !m_axis_tready;
    assign load  = tok_v[CAPACITY] && !stall;

    // result from the word leaving the chain
    always_comb begin
        n_status  = ST_MISS;
        n_payload = '0;
        case (last.kind)
            KIND_INSERT: n_status = last.done ? ST_OK : ST_FULL;
            KIND_LOOKUP, KIND_REMOVE: begin
                if (last.hit) begin
                    n_status  = ST_OK;
                    n_payload = last.best_payload;
                end
            end
            default: n_status = ST_MISS;
        endcase
    end

    // control: busy flag, insert counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_stamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (load && last.kind == KIND_INSERT && last.done) begin
                r_stamp <= r_stamp + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output data register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status  <= n_status;
            r_out_payload <= n_payload;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_payload[15:0], r_out_payload[31:16],
                            r_out_payload[47:32]};

    // at most one operation in the chain
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_v))
        else $error("more than one operation in the cell chain");

    // a result only comes from an operation that was taken
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_busy)
        else $error("result produced while idle");

    // a stalled chain never holds an operation short of the end
    a_stall_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> $onehot(tok_v) && tok_v[CAPACITY])
        else $error("chain stalled with operation inside");

    // the counter moves only on a stored insert
    a_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_stamp))
        else $error("insert counter moved without a result");

endmodule

### test/testbench.sv
module testbench;
    import ctt_pkg::*;

    localparam int NumRandom = 870;
    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 2 * CttCapacity + 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] local_addr;
        logic [31:0] foreign_addr;
        logic [15:0] local_port;
        logic [15:0] foreign_port;
        logic [15:0] record_version;
        logic [15:0] greeting_version;
        logic [15:0] suite_list_length;
    } t_op;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] record_version;
        logic [15:0] greeting_version;
        logic [15:0] suite_list_length;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    connection_tuple_table_core DUT (.*);

    always #4 i_clk = ~i_clk;

    // flow table shadow
    logic        tbl_valid [CttCapacity];
    logic [63:0] tbl_addrs [CttCapacity];
    logic [31:0] tbl_ports [CttCapacity];
    logic [47:0] tbl_payload [CttCapacity];
    logic [31:0] tbl_stamp [CttCapacity];
    logic [31:0] stamp_count;

    t_op  op_queue[$];
    t_res expected_results[$];
    int   errors = 0;
    int   cycle_count = 0;
    bit   stim_done = 0;

    // few keys so that matches and duplicates are common
    logic [95:0] key_pool [8];

    function automatic t_res apply_op(t_op op);
        t_res r;
        int pick;
        logic [31:0] age, best;
        logic [63:0] a;
        logic [31:0] p;
        r = '0;
        pick = -1;
        best = '0;
        a = {op.local_addr, op.foreign_addr};
        p = {op.local_port, op.foreign_port};
        if (op.kind == KIND_INSERT) begin
            for (int i = 0; i < CttCapacity; i++)
                if (!tbl_valid[i] && pick < 0) pick = i;
            if (pick < 0) begin
                r.status = ST_FULL;
            end else begin
                stamp_count = stamp_count + 32'd1;
                tbl_valid[pick] = 1'b1;
                tbl_addrs[pick] = a;
                tbl_ports[pick] = p;
                tbl_payload[pick] = {op.record_version, op.greeting_version,
                                     op.suite_list_length};
                tbl_stamp[pick] = stamp_count;
                r.status = ST_OK;
            end
        end else if (op.kind == KIND_LOOKUP || op.kind == KIND_REMOVE) begin
            for (int i = 0; i < CttCapacity; i++) begin
                if (tbl_valid[i] && tbl_addrs[i] == a && tbl_ports[i] == p) begin
                    age = stamp_count - tbl_stamp[i];
                    if (pick < 0 || (op.kind == KIND_LOOKUP ? age < best : age > best)) begin
                        pick = i;
                        best = age;
                    end
                    if (op.kind == KIND_REMOVE) tbl_valid[i] = 1'b0;
                end
            end
            if (pick < 0) r.status = ST_MISS;
            else r = {ST_OK, tbl_payload[pick]};
        end else begin
            r.status = ST_MISS;
        end
        return r;
    endfunction

    function automatic t_op make_op(logic [1:0] kind, int key_sel);
        t_op op;
        op.kind = kind;
        {op.local_addr, op.foreign_addr, op.local_port, op.foreign_port} =
            key_sel < 0 ? {$urandom, $urandom, $urandom} : key_pool[key_sel];
        op.record_version = 16'($urandom);
        op.greeting_version = 16'($urandom);
        op.suite_list_length = 16'($urandom);
        return op;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // stimulus
    initial begin
        t_op op;
        int r;
        for (int i = 0; i < CttCapacity; i++) tbl_valid[i] = 1'b0;
        stamp_count = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 8; k++) key_pool[k] = {$urandom, $urandom, $urandom};
        // directed: miss on empty, extremes, duplicates, unused kind
        op_queue.push_back(make_op(KIND_LOOKUP, 0));
        op_queue.push_back(make_op(KIND_REMOVE, 1));
        op = make_op(KIND_INSERT, 0);
        {op.record_version, op.greeting_version, op.suite_list_length} = '0;
        op_queue.push_back(op);
        op = make_op(KIND_INSERT, 1);
        {op.record_version, op.greeting_version, op.suite_list_length} = '1;
        op_queue.push_back(op);
        op_queue.push_back(make_op(KIND_INSERT, 1));
        op_queue.push_back(make_op(KIND_LOOKUP, 1));
        op_queue.push_back(make_op(KIND_LOOKUP, 0));
        op_queue.push_back(make_op(KIND_UNUSED, 0));
        op_queue.push_back(make_op(KIND_REMOVE, 1));
        op_queue.push_back(make_op(KIND_LOOKUP, 1));
        op_queue.push_back(make_op(KIND_REMOVE, 0));
        // fill the pool past full, then drain it
        for (int i = 0; i < CttCapacity + 3; i++)
            op_queue.push_back(make_op(KIND_INSERT, i % 3 + 2));
        for (int k = 2; k < 5; k++) op_queue.push_back(make_op(KIND_REMOVE, k));
        // random mix over a small key set
        for (int i = 0; i < NumRandom; i++) begin
            r = $urandom_range(0, 99);
            op = make_op(r < 45 ? KIND_INSERT : r < 75 ? KIND_LOOKUP :
                         r < 97 ? KIND_REMOVE : KIND_UNUSED,
                         $urandom_range(0, 9) == 0 ? -1 : int'($urandom_range(0, 7)));
            op_queue.push_back(op);
        end
    end

    // driver: bursts with gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 10) i_rst_n <= 1'b1;
        m_axis_tready <= ($urandom_range(0, 3) != 0) || (cycle_count % 512 < 128);
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                t_op op;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    op = op_queue.pop_front();
                    expected_results.push_back(apply_op(op));
                    s_axis_tuser <= op.kind;
                    s_axis_tdata <= {op.suite_list_length, op.greeting_version,
                                     op.record_version, op.foreign_port, op.local_port,
                                     op.foreign_addr, op.local_addr};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", 16'(m_axis_tuser), 16'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 16'(m_axis_tuser), 16'(want.status));
                if (m_axis_tdata[15:0] != want.record_version)
                    report_mismatch("record_version", m_axis_tdata[15:0],
                                    want.record_version);
                if (m_axis_tdata[31:16] != want.greeting_version)
                    report_mismatch("greeting_version", m_axis_tdata[31:16],
                                    want.greeting_version);
                if (m_axis_tdata[47:32] != want.suite_list_length)
                    report_mismatch("suite_list_length", m_axis_tdata[47:32],
                                    want.suite_list_length);
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done && expected_results.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("testbench failed");
        $finish;
    end
endmodule
